// File: sv/normalized_image_convolution_macros.svh
// Assertion macros shared by the convolution RTL.
`ifndef NORMALIZED_IMAGE_CONVOLUTION_MACROS_SVH
`define NORMALIZED_IMAGE_CONVOLUTION_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define NIC_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("nic check failed");

// Check an implication at every clock edge outside reset.
`define NIC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nic check failed");

`endif

// File: sv/nic_pkg.sv
// Shared types and constants of the normalized convolution block.
package nic_pkg;

  localparam int LINE_DEPTH = 1024;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  localparam int PIX_W   = 16;
  localparam int COEF_W  = 16;
  localparam int CROW_W  = 48;
  localparam int PROD_W  = 33;
  localparam int ACC_W   = 37;
  localparam int KSUM_W  = 20;
  localparam int DEN_W   = 20;
  localparam int QUO_W   = 37;

  localparam logic [3:0] MAC_LAST = 4'd9;
  localparam logic [5:0] DIV_LAST = 6'(QUO_W - 1);

  localparam logic [2:0] CFG_COEF_ABOVE  = 3'd0;
  localparam logic [2:0] CFG_COEF_CENTER = 3'd1;
  localparam logic [2:0] CFG_COEF_BELOW  = 3'd2;
  localparam logic [2:0] CFG_WIDTH       = 3'd3;
  localparam logic [2:0] CFG_HEIGHT      = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_UPD, ST_MAC, ST_PREP, ST_DIV, ST_FIN
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       read;
    logic       update;
    logic       mac_clr;
    logic       mac_mul;
    logic       mac_acc;
    logic [3:0] tap;
    logic       prep;
    logic       div_step;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic emit_any;
    logic more;
    logic out_free;
  } sts_t;

endpackage

// File: sv/nic_ctrl.sv
// Sequencer of the normalized convolution block.
`include "normalized_image_convolution_macros.svh"

module nic_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  nic_pkg::sts_t sts,
  output nic_pkg::cmd_t cmd
);

  nic_pkg::state_t state_r, state_nxt;
  logic [3:0] tap_r, tap_nxt;
  logic [5:0] bit_r, bit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nic_pkg::ST_IDLE;
      tap_r   <= '0;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
      bit_r   <= bit_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    bit_nxt   = bit_r;
    cmd       = '0;
    cmd.tap   = tap_r;
    in_ready  = 1'b0;
    case (state_r)
      nic_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = nic_pkg::ST_READ;
        end
      end
      nic_pkg::ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = nic_pkg::ST_UPD;
      end
      nic_pkg::ST_UPD: begin
        cmd.update = 1'b1;
        tap_nxt    = '0;
        state_nxt  = sts.emit_any ? nic_pkg::ST_MAC : nic_pkg::ST_IDLE;
      end
      nic_pkg::ST_MAC: begin
        cmd.mac_clr = (tap_r == 4'd0);
        cmd.mac_mul = (tap_r != nic_pkg::MAC_LAST);
        cmd.mac_acc = (tap_r != 4'd0);
        if (tap_r == nic_pkg::MAC_LAST) begin
          state_nxt = nic_pkg::ST_PREP;
        end else begin
          tap_nxt = tap_r + 4'd1;
        end
      end
      nic_pkg::ST_PREP: begin
        cmd.prep  = 1'b1;
        bit_nxt   = '0;
        state_nxt = nic_pkg::ST_DIV;
      end
      nic_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        bit_nxt      = bit_r + 6'd1;
        if (bit_r == nic_pkg::DIV_LAST) begin
          state_nxt = nic_pkg::ST_FIN;
        end
      end
      nic_pkg::ST_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          tap_nxt      = '0;
          state_nxt    = sts.more ? nic_pkg::ST_MAC : nic_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nic_pkg::ST_IDLE;
    endcase
  end

  `NIC_ASSERT_NEXT(a_fin_holds, state_r == nic_pkg::ST_FIN && !sts.out_free, state_r == nic_pkg::ST_FIN)
  `NIC_ASSERT_NEXT(a_no_emit_idle, state_r == nic_pkg::ST_UPD && !sts.emit_any, state_r == nic_pkg::ST_IDLE)
  `NIC_ASSERT_NEXT(a_div_len, state_r == nic_pkg::ST_PREP, bit_r == 6'd0 && state_r == nic_pkg::ST_DIV)

endmodule

// File: sv/nic_dp.sv
// Datapath: line stores, window, serial MAC, divider and result register.
`include "normalized_image_convolution_macros.svh"

module nic_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  nic_pkg::cmd_t cmd,
  output nic_pkg::sts_t sts,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [47:0]   cfg_data,
  input  logic [15:0]   in_pixel,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [15:0]   out_value,
  output logic [9:0]    out_col,
  output logic [11:0]   out_row,
  output logic          out_saturated,
  output logic          out_zero_weight,
  output logic          out_last
);

  localparam int AW = nic_pkg::LINE_AW;
  localparam int RW = nic_pkg::ROW_W;

  // configuration
  logic [nic_pkg::CROW_W-1:0] coef_r [3];
  logic [10:0] width_r;
  logic [12:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[0] <= '0;
      coef_r[1] <= 48'h0000_0001_0000;
      coef_r[2] <= '0;
      width_r   <= 11'd1024;
      height_r  <= 13'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        nic_pkg::CFG_COEF_ABOVE:  coef_r[0] <= cfg_data;
        nic_pkg::CFG_COEF_CENTER: coef_r[1] <= cfg_data;
        nic_pkg::CFG_COEF_BELOW:  coef_r[2] <= cfg_data;
        nic_pkg::CFG_WIDTH:       width_r   <= cfg_data[10:0];
        nic_pkg::CFG_HEIGHT:      height_r  <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  logic [AW:0] weff;
  logic [RW:0] heff;
  always_comb begin
    if (width_r == '0)                             weff = (AW+1)'(1);
    else if ({2'b0, width_r} > 13'(nic_pkg::LINE_DEPTH)) weff = (AW+1)'(nic_pkg::LINE_DEPTH);
    else                                           weff = (AW+1)'(width_r);
    if (height_r == '0)                              heff = (RW+1)'(1);
    else if (height_r > 13'(nic_pkg::MAX_HEIGHT))    heff = (RW+1)'(nic_pkg::MAX_HEIGHT);
    else                                             heff = (RW+1)'(height_r);
  end

  // position
  logic [AW-1:0] col_cnt_r, c_r;
  logic [RW-1:0] row_cnt_r, r_r;
  logic [15:0]   pix_r;
  logic [AW:0]   c_wrap;
  logic [RW:0]   r_wrap;

  always_comb begin
    c_wrap = {1'b0, col_cnt_r};
    r_wrap = {1'b0, row_cnt_r};
    if (c_wrap >= weff) begin
      c_wrap = '0;
      r_wrap = r_wrap + (RW+1)'(1);
    end
    if (r_wrap >= heff) r_wrap = '0;
  end

  // line stores
  logic [15:0] older_mem [nic_pkg::LINE_DEPTH];
  logic [15:0] newer_mem [nic_pkg::LINE_DEPTH];
  logic [15:0] up2_r, up1_r;

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      up2_r <= older_mem[c_r];
      up1_r <= newer_mem[c_r];
    end
    if (cmd.update) begin
      older_mem[c_r] <= up1_r;
      newer_mem[c_r] <= pix_r;
    end
  end

  // emit flags
  logic c_ge1, c_ge2, r_ge1, r_ge2, c_last, r_last;
  logic [3:0] pend_calc, pend_r, cur_hot;
  logic [AW:0] c_ext, c_inc;
  logic [RW:0] r_ext, r_inc;
  assign c_ext  = {1'b0, c_r};
  assign r_ext  = {1'b0, r_r};
  assign c_ge1  = (c_r != '0);
  assign c_ge2  = (c_r > AW'(1));
  assign r_ge1  = (r_r != '0);
  assign r_ge2  = (r_r > RW'(1));
  assign c_last = (c_ext == weff - (AW+1)'(1));
  assign r_last = (r_ext == heff - (RW+1)'(1));
  assign pend_calc = {r_last & c_last, r_last & c_ge1, r_ge1 & c_last, r_ge1 & c_ge1};
  assign cur_hot   = pend_r & (~pend_r + 4'd1);
  assign c_inc = c_ext + (AW+1)'(1);
  assign r_inc = r_ext + (RW+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      pend_r    <= '0;
    end else begin
      if (cmd.update) begin
        pend_r <= pend_calc;
        if (c_inc >= weff) begin
          col_cnt_r <= '0;
          row_cnt_r <= (r_inc >= heff) ? '0 : r_inc[RW-1:0];
        end else begin
          col_cnt_r <= c_inc[AW-1:0];
          row_cnt_r <= r_r;
        end
      end else if (cmd.load_out) begin
        pend_r <= pend_r & ~cur_hot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r <= in_pixel;
      c_r   <= c_wrap[AW-1:0];
      r_r   <= r_wrap[RW-1:0];
    end
  end

  // window: index row*3+col, rows r-2..r, cols c-2..c
  logic [15:0] win_r [9];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else if (cmd.update) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k*3]   <= win_r[k*3+1];
        win_r[k*3+1] <= win_r[k*3+2];
      end
      win_r[2] <= up2_r;
      win_r[5] <= up1_r;
      win_r[8] <= pix_r;
    end
  end

  // tap selection for the current result
  logic        use_last_row, use_end_col;
  logic [1:0]  dy, dx, wr, wc;
  logic [3:0]  widx;
  logic [15:0] tap_pix;
  logic signed [15:0] tap_coef;
  logic [47:0] crow;

  assign use_last_row = cur_hot[2] | cur_hot[3];
  assign use_end_col  = cur_hot[1] | cur_hot[3];

  always_comb begin
    case (cmd.tap)
      4'd0, 4'd1, 4'd2: dy = 2'd0;
      4'd3, 4'd4, 4'd5: dy = 2'd1;
      default:          dy = 2'd2;
    endcase
    case (cmd.tap)
      4'd0, 4'd3, 4'd6: dx = 2'd0;
      4'd1, 4'd4, 4'd7: dx = 2'd1;
      default:          dx = 2'd2;
    endcase
    if (dy == 2'd0) begin
      if (use_last_row) wr = r_ge1 ? 2'd1 : 2'd2;
      else              wr = r_ge2 ? 2'd0 : 2'd1;
    end else if (dy == 2'd1) begin
      wr = use_last_row ? 2'd2 : 2'd1;
    end else begin
      wr = 2'd2;
    end
    if (dx == 2'd0) begin
      if (use_end_col) wc = c_ge1 ? 2'd1 : 2'd2;
      else             wc = c_ge2 ? 2'd0 : 2'd1;
    end else if (dx == 2'd1) begin
      wc = use_end_col ? 2'd2 : 2'd1;
    end else begin
      wc = 2'd2;
    end
    widx     = ({2'b0, wr} * 4'd3) + {2'b0, wc};
    tap_pix  = (widx < 4'd9) ? win_r[widx] : '0;
    crow     = coef_r[dy];
    case (dx)
      2'd0:    tap_coef = crow[15:0];
      2'd1:    tap_coef = crow[31:16];
      default: tap_coef = crow[47:32];
    endcase
  end

  // serial multiply-accumulate
  logic signed [nic_pkg::PROD_W-1:0] prod_r;
  logic signed [nic_pkg::ACC_W-1:0]  acc_r;
  logic signed [nic_pkg::KSUM_W-1:0] ksum_r;

  always_ff @(posedge clk) begin
    if (cmd.mac_mul) prod_r <= $signed({1'b0, tap_pix}) * tap_coef;
    if (cmd.mac_clr) begin
      acc_r  <= '0;
      ksum_r <= nic_pkg::KSUM_W'(tap_coef);
    end else begin
      if (cmd.mac_acc) acc_r <= acc_r + nic_pkg::ACC_W'(prod_r);
      if (cmd.mac_mul) ksum_r <= ksum_r + nic_pkg::KSUM_W'(tap_coef);
    end
  end

  // restoring divider, one quotient bit a cycle
  logic [nic_pkg::ACC_W-1:0]  sm;
  logic [nic_pkg::KSUM_W-1:0] km;
  logic [nic_pkg::QUO_W-1:0]  quo_r;
  logic [nic_pkg::DEN_W-1:0]  den_r, rem_r;
  logic [nic_pkg::DEN_W:0]    rem_sh, rem_diff;
  logic neg_r, zw_r;

  assign sm       = acc_r[nic_pkg::ACC_W-1] ? -acc_r : acc_r;
  assign km       = ksum_r[nic_pkg::KSUM_W-1] ? -ksum_r : ksum_r;
  assign rem_sh   = {rem_r, quo_r[nic_pkg::QUO_W-1]};
  assign rem_diff = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      quo_r <= {sm[nic_pkg::QUO_W-2:0], 1'b0} + nic_pkg::QUO_W'(km);
      den_r <= {km[nic_pkg::DEN_W-2:0], 1'b0};
      rem_r <= '0;
      neg_r <= acc_r[nic_pkg::ACC_W-1] ^ ksum_r[nic_pkg::KSUM_W-1];
      zw_r  <= (ksum_r == '0);
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_r <= rem_diff[nic_pkg::DEN_W-1:0];
        quo_r <= {quo_r[nic_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[nic_pkg::DEN_W-1:0];
        quo_r <= {quo_r[nic_pkg::QUO_W-2:0], 1'b0};
      end
    end
  end

  // result register
  logic        out_valid_r;
  logic [15:0] val_nxt;
  logic        sat_nxt;
  logic [AW-1:0] ocol_nxt;
  logic [RW-1:0] orow_nxt;

  always_comb begin
    val_nxt = '0;
    sat_nxt = 1'b0;
    if (zw_r) begin
      val_nxt = '0;
    end else if (neg_r && quo_r != '0) begin
      sat_nxt = 1'b1;
    end else if (quo_r[nic_pkg::QUO_W-1:16] != '0) begin
      val_nxt = 16'hFFFF;
      sat_nxt = 1'b1;
    end else begin
      val_nxt = quo_r[15:0];
    end
    ocol_nxt = use_end_col  ? c_r : c_r - AW'(1);
    orow_nxt = use_last_row ? r_r : r_r - RW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_value       <= val_nxt;
      out_saturated   <= sat_nxt;
      out_zero_weight <= zw_r;
      out_col         <= ocol_nxt;
      out_row         <= orow_nxt;
      out_last        <= ((pend_r & ~cur_hot) == '0);
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.emit_any = (pend_calc != '0);
  assign sts.more     = ((pend_r & ~cur_hot) != '0);
  assign sts.out_free = !out_valid_r || out_ready;

  `NIC_ASSERT(a_update_empty, !cmd.update || pend_r == '0)
  `NIC_ASSERT(a_load_pending, !cmd.load_out || pend_r != '0)
  `NIC_ASSERT_NEXT(a_load_shows, cmd.load_out, out_valid_r)

endmodule

// File: sv/normalized_image_convolution.sv
// An item is taken, its line stores are read and its window is updated; each
// pending result then runs the serial MAC, a divider setup, the bit-serial divider
// and a load that waits while an earlier result is unread. No new item is taken
// until its results are loaded; the single shared multiplier and divider set the rate.
// Reset (synchronous, rst_n low): counters, window, pending results and config
// registers return to defaults; the line stores are not cleared.
module normalized_image_convolution (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  // pixel request
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_pixel,
  // result request
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_value,
  output logic [9:0]  out_col,
  output logic [11:0] out_row,
  output logic        out_saturated,
  output logic        out_zero_weight,
  output logic        out_last
);

  // command and status between sequencer and datapath
  nic_pkg::cmd_t cmd;
  nic_pkg::sts_t sts;

  // sequencer: accept one pixel, walk the pending results through MAC and divider
  nic_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: hold line stores and window, compute and register each result
  nic_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_pixel        (in_pixel),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .out_col         (out_col),
    .out_row         (out_row),
    .out_saturated   (out_saturated),
    .out_zero_weight (out_zero_weight),
    .out_last        (out_last)
  );

endmodule
